>>> hw/rtl/pgse_pkg.sv
`timescale 1ns / 1ps

package pgse_pkg;

    // Field widths of the request, response and configuration channels.
    localparam int REQ_TYPE_W = 2;
    localparam int INDEX_W    = 10;
    localparam int PART_W     = 16;
    localparam int GATE_W     = 2;
    localparam int QUBIT_W    = 4;
    localparam int QCFG_W     = 4;

    localparam logic [QCFG_W-1:0] QUBITS_RESET = 4'd10;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_LOAD = 2'd0,
        REQ_READ = 2'd1,
        REQ_GATE = 2'd2
    } req_code_t;

    typedef enum logic [GATE_W-1:0] {
        GATE_X = 2'd0,
        GATE_Y = 2'd1,
        GATE_Z = 2'd2
    } gate_code_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GATE,
        ST_FINISH
    } pgse_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic out_load;
    } pgse_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic gate_ok;
        logic gate_done;
    } pgse_stat_t;

endpackage

>>> hw/rtl/pgse_if.sv
`timescale 1ns / 1ps

interface pgse_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [pgse_pkg::REQ_TYPE_W-1:0]        req_type;
    logic [pgse_pkg::INDEX_W-1:0]           amp_index;
    logic signed [pgse_pkg::PART_W-1:0]     real_in;
    logic signed [pgse_pkg::PART_W-1:0]     imag_in;
    logic [pgse_pkg::GATE_W-1:0]            gate_kind;
    logic [pgse_pkg::QUBIT_W-1:0]           target_qubit;

    modport source (
        output valid, req_type, amp_index, real_in, imag_in, gate_kind, target_qubit,
        input  ready
    );
    modport sink (
        input  valid, req_type, amp_index, real_in, imag_in, gate_kind, target_qubit,
        output ready
    );
endinterface

interface pgse_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [pgse_pkg::PART_W-1:0]     real_out;
    logic signed [pgse_pkg::PART_W-1:0]     imag_out;
    logic                                   status;

    modport source (
        output valid, real_out, imag_out, status,
        input  ready
    );
    modport sink (
        input  valid, real_out, imag_out, status,
        output ready
    );
endinterface

interface pgse_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [pgse_pkg::QCFG_W-1:0]            qubits_in_use;

    modport source (
        output valid, qubits_in_use,
        input  ready
    );
    modport sink (
        input  valid, qubits_in_use,
        output ready
    );
endinterface

>>> hw/rtl/pgse_ctrl.sv
`timescale 1ns / 1ps

module pgse_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  pgse_pkg::pgse_stat_t stat,
    output pgse_pkg::pgse_cmd_t  cmd
);
    import pgse_pkg::*;

    pgse_state_t state_reg;
    pgse_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        req_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.gate_ok ? ST_GATE : ST_FINISH;
                end
            end
            ST_GATE:
            begin
                if (stat.gate_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // The result moves to the output register once it is free.
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

>>> hw/rtl/pgse_datapath.sv
`timescale 1ns / 1ps

module pgse_datapath #(
    parameter int MAX_QUBITS = 10,
    parameter int AMP_BITS   = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pgse_pkg::pgse_cmd_t                cmd,
    output pgse_pkg::pgse_stat_t               stat,
    input  logic                               cfg_we,
    input  logic [pgse_pkg::QCFG_W-1:0]        cfg_data,
    input  logic [pgse_pkg::REQ_TYPE_W-1:0]    req_type,
    input  logic [pgse_pkg::INDEX_W-1:0]       amp_index,
    input  logic signed [pgse_pkg::PART_W-1:0] real_in,
    input  logic signed [pgse_pkg::PART_W-1:0] imag_in,
    input  logic [pgse_pkg::GATE_W-1:0]        gate_kind,
    input  logic [pgse_pkg::QUBIT_W-1:0]       target_qubit,
    output logic signed [pgse_pkg::PART_W-1:0] real_out,
    output logic signed [pgse_pkg::PART_W-1:0] imag_out,
    output logic                               status
);
    import pgse_pkg::*;

    localparam int ADDR_W = MAX_QUBITS;
    localparam int DEPTH  = 1 << MAX_QUBITS;
    localparam int NQ_W   = $clog2(MAX_QUBITS + 1);
    localparam int CMP_W  = (NQ_W > QUBIT_W) ? NQ_W : QUBIT_W;
    localparam int SAT_W  = ((AMP_BITS > PART_W) ? AMP_BITS : PART_W) + 1;

    localparam logic signed [AMP_BITS-1:0] A_MAX = {1'b0, {(AMP_BITS-1){1'b1}}};
    localparam logic signed [AMP_BITS-1:0] A_MIN = {1'b1, {(AMP_BITS-1){1'b0}}};
    localparam logic signed [SAT_W-1:0]    W_AMAX = SAT_W'(A_MAX);
    localparam logic signed [SAT_W-1:0]    W_AMIN = SAT_W'(A_MIN);
    localparam logic signed [SAT_W-1:0]    W_FMAX = SAT_W'(32767);
    localparam logic signed [SAT_W-1:0]    W_FMIN = -W_FMAX - SAT_W'(1);

    typedef struct packed {
        logic signed [AMP_BITS-1:0] re;
        logic signed [AMP_BITS-1:0] im;
    } amp_t;

    function automatic logic signed [AMP_BITS-1:0] load_sat(
        input logic signed [PART_W-1:0] v
    );
        logic signed [SAT_W-1:0] w;
        begin
            w = SAT_W'(v);
            if (w > W_AMAX)
            begin
                w = W_AMAX;
            end
            else if (w < W_AMIN)
            begin
                w = W_AMIN;
            end
            load_sat = w[AMP_BITS-1:0];
        end
    endfunction

    function automatic logic signed [PART_W-1:0] read_sat(
        input logic signed [AMP_BITS-1:0] v
    );
        logic signed [SAT_W-1:0] w;
        begin
            w = SAT_W'(v);
            if (w > W_FMAX)
            begin
                w = W_FMAX;
            end
            else if (w < W_FMIN)
            begin
                w = W_FMIN;
            end
            read_sat = w[PART_W-1:0];
        end
    endfunction

    function automatic logic signed [AMP_BITS-1:0] neg_sat(
        input logic signed [AMP_BITS-1:0] v
    );
        begin
            neg_sat = (v == A_MIN) ? A_MAX : -v;
        end
    endfunction

    amp_t mem [DEPTH];

    logic [QCFG_W-1:0]   qubits_reg;
    logic [NQ_W-1:0]     n_eff;
    logic [NQ_W:0]       last_sh;
    logic                idx_ok;
    logic                q_ok;
    logic                kind_ok;
    logic                load_ok;
    logic                read_ok;
    logic                gate_ok;

    logic                res_status_reg;
    logic                res_read_reg;
    logic [GATE_W-1:0]   kind_reg;
    logic [QUBIT_W-1:0]  q_reg;
    logic [ADDR_W-1:0]   last_reg;
    logic [ADDR_W-1:0]   cnt_reg;
    logic                ph_reg;
    logic                issue_reg;

    logic                tag_vld_reg;
    logic                tag_ph_reg;
    logic                tag_last_reg;
    logic [ADDR_W-1:0]   tag_addr_reg;
    amp_t                a0_reg;
    amp_t                rdata_reg;

    logic                wb_vld_reg;
    logic                wb_last_reg;
    logic [ADDR_W-1:0]   wb_addr_reg;
    amp_t                wb_data_reg;

    logic [ADDR_W-1:0]   bit_mask;
    logic [ADDR_W-1:0]   low_mask;
    logic [ADDR_W-1:0]   idx0;
    logic [ADDR_W-1:0]   idx1;
    logic                cnt_last;
    amp_t                new0;
    amp_t                new1;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    amp_t                mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;

    logic signed [PART_W-1:0] real_out_reg;
    logic signed [PART_W-1:0] imag_out_reg;
    logic                     status_reg;

    // Request decode against the effective qubit count.
    always_comb
    begin
        if (qubits_reg == '0)
        begin
            n_eff = NQ_W'(1);
        end
        else if (int'(qubits_reg) > MAX_QUBITS)
        begin
            n_eff = NQ_W'(MAX_QUBITS);
        end
        else
        begin
            n_eff = NQ_W'(qubits_reg);
        end
        idx_ok  = (amp_index >> n_eff) == '0;
        q_ok    = CMP_W'(target_qubit) < CMP_W'(n_eff);
        kind_ok = gate_kind inside {GATE_X, GATE_Y, GATE_Z};
        load_ok = (req_type == REQ_LOAD) && idx_ok;
        read_ok = (req_type == REQ_READ) && idx_ok;
        gate_ok = (req_type == REQ_GATE) && kind_ok && q_ok;
        last_sh = (NQ_W+1)'(MAX_QUBITS) - (NQ_W+1)'(n_eff) + (NQ_W+1)'(1);
    end

    // The pair counter runs over 2^(n-1) pairs; the target bit is inserted as
    // zero to form the lower index of each pair.
    always_comb
    begin
        bit_mask = ADDR_W'(1) << q_reg;
        low_mask = ~({ADDR_W{1'b1}} << q_reg);
        idx0     = ((cnt_reg & ~low_mask) << 1) | (cnt_reg & low_mask);
        idx1     = idx0 | bit_mask;
        cnt_last = (cnt_reg == last_reg);
    end

    // Gate arithmetic on a complete pair: a0 from a0_reg, a1 on the read port.
    always_comb
    begin
        case (kind_reg)
            GATE_X:
            begin
                new0 = rdata_reg;
                new1 = a0_reg;
            end
            GATE_Y:
            begin
                new0.re = rdata_reg.im;
                new0.im = neg_sat(rdata_reg.re);
                new1.re = neg_sat(a0_reg.im);
                new1.im = a0_reg.re;
            end
            default:
            begin
                new0    = a0_reg;
                new1.re = neg_sat(rdata_reg.re);
                new1.im = neg_sat(rdata_reg.im);
            end
        endcase
    end

    // Memory port selection. The lower member of a pair is written in the
    // cycle its partner arrives, the upper member in the cycle after.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = tag_addr_reg & ~bit_mask;
        mem_wdata = new0;
        if (tag_vld_reg && tag_ph_reg)
        begin
            mem_we = 1'b1;
        end
        else if (wb_vld_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = wb_addr_reg;
            mem_wdata = wb_data_reg;
        end
        else if (cmd.accept && load_ok)
        begin
            mem_we          = 1'b1;
            mem_waddr       = ADDR_W'(amp_index);
            mem_wdata.re    = load_sat(real_in);
            mem_wdata.im    = load_sat(imag_in);
        end

        mem_re    = 1'b0;
        mem_raddr = ph_reg ? idx1 : idx0;
        if (issue_reg)
        begin
            mem_re = 1'b1;
        end
        else if (cmd.accept && read_ok)
        begin
            mem_re    = 1'b1;
            mem_raddr = ADDR_W'(amp_index);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qubits_reg  <= QUBITS_RESET;
            issue_reg   <= 1'b0;
            ph_reg      <= 1'b0;
            tag_vld_reg <= 1'b0;
            wb_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                qubits_reg <= cfg_data;
            end

            if (cmd.accept && gate_ok)
            begin
                issue_reg <= 1'b1;
                ph_reg    <= 1'b0;
            end
            else if (issue_reg)
            begin
                ph_reg <= ~ph_reg;
                if (ph_reg && cnt_last)
                begin
                    issue_reg <= 1'b0;
                end
            end

            tag_vld_reg <= issue_reg;
            wb_vld_reg  <= tag_vld_reg && tag_ph_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            res_status_reg <= !(load_ok || read_ok || gate_ok);
            res_read_reg   <= read_ok;
        end

        if (cmd.accept && gate_ok)
        begin
            kind_reg <= gate_kind;
            q_reg    <= target_qubit;
            last_reg <= {ADDR_W{1'b1}} >> last_sh;
            cnt_reg  <= '0;
        end
        else if (issue_reg && ph_reg)
        begin
            cnt_reg <= cnt_reg + ADDR_W'(1);
        end

        tag_ph_reg   <= ph_reg;
        tag_last_reg <= cnt_last;
        tag_addr_reg <= mem_raddr;

        if (tag_vld_reg && !tag_ph_reg)
        begin
            a0_reg <= rdata_reg;
        end

        wb_addr_reg <= tag_addr_reg;
        wb_data_reg <= new1;
        wb_last_reg <= tag_last_reg;

        if (cmd.out_load)
        begin
            real_out_reg <= res_read_reg ? read_sat(rdata_reg.re) : '0;
            imag_out_reg <= res_read_reg ? read_sat(rdata_reg.im) : '0;
            status_reg   <= res_status_reg;
        end
    end

    assign stat.gate_ok   = gate_ok;
    assign stat.gate_done = wb_vld_reg && wb_last_reg;

    assign real_out = real_out_reg;
    assign imag_out = imag_out_reg;
    assign status   = status_reg;

endmodule

>>> hw/rtl/pauli_gate_state_vector_engine.sv
`timescale 1ns / 1ps

// State-vector engine for Pauli gates: 2^MAX_QUBITS complex amplitudes of two
// AMP_BITS-bit fixed-point parts sit in one on-chip RAM with one write and
// one registered read port. Every request transaction returns exactly one
// response transaction. A load, a read or a rejected request is accepted,
// then its result moves to the output register once that is free. A gate
// walks the vector for n qubits in use: each amplitude pair needs two reads
// on the single read port, and the write-back overlaps the next pair's reads.
// The store has no reset: an amplitude must be loaded before a read or a
// gate touches it. The user must write the qubit count only while no request
// is in flight; the block itself does not enforce it.
module pauli_gate_state_vector_engine #(
    parameter int MAX_QUBITS = 10,
    parameter int AMP_BITS   = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    pgse_req_if.sink   req,
    pgse_rsp_if.source rsp,
    pgse_cfg_if.sink   cfg
);
    import pgse_pkg::*;

    pgse_cmd_t  cmd;
    pgse_stat_t stat;

    assign cfg.ready = 1'b1;

    pgse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pgse_datapath #(
        .MAX_QUBITS (MAX_QUBITS),
        .AMP_BITS   (AMP_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg.valid),
        .cfg_data     (cfg.qubits_in_use),
        .req_type     (req.req_type),
        .amp_index    (req.amp_index),
        .real_in      (req.real_in),
        .imag_in      (req.imag_in),
        .gate_kind    (req.gate_kind),
        .target_qubit (req.target_qubit),
        .real_out     (rsp.real_out),
        .imag_out     (rsp.imag_out),
        .status       (rsp.status)
    );

endmodule

>>> bench/pauli_gate_state_vector_engine_checker.sv
`timescale 1ns / 1ps

module pauli_gate_state_vector_engine_checker #(
    parameter int MAX_QUBITS = 10
) (
    input  logic  clk,
    input  logic  rst_n,
    pgse_req_if   req,
    pgse_rsp_if   rsp,
    pgse_cfg_if   cfg,
    output int    mismatches,
    output int    pending
);
    import pgse_pkg::*;

    localparam int DEPTH = 1 << MAX_QUBITS;
    localparam logic signed [PART_W-1:0] PART_MAX = 16'sh7fff;
    localparam logic signed [PART_W-1:0] PART_MIN = 16'sh8000;

    typedef struct {
        logic signed [PART_W-1:0] re;
        logic signed [PART_W-1:0] im;
        logic                     status;
    } reply_t;

    logic signed [PART_W-1:0] amp_re [DEPTH];
    logic signed [PART_W-1:0] amp_im [DEPTH];
    logic [QCFG_W-1:0]        qubits_cfg;
    reply_t                   awaited_replies [$];

    function automatic logic signed [PART_W-1:0] negate_sat(input logic signed [PART_W-1:0] v);
        return (v == PART_MIN) ? PART_MAX : -v;
    endfunction

    // Applies one request to the shadow state vector and returns the reply it must produce.
    function automatic reply_t serve_request(
        input logic [REQ_TYPE_W-1:0]   kind,
        input logic [INDEX_W-1:0]      idx,
        input logic signed [PART_W-1:0] re_in,
        input logic signed [PART_W-1:0] im_in,
        input logic [GATE_W-1:0]       gk,
        input logic [QUBIT_W-1:0]      q
    );
        reply_t r;
        int n;
        int dim;
        int bit_mask;
        int j;
        logic signed [PART_W-1:0] r0, i0, r1, i1;
        r.re = '0;
        r.im = '0;
        r.status = 1'b1;
        if (qubits_cfg == 0)
            n = 1;
        else if (qubits_cfg > MAX_QUBITS)
            n = MAX_QUBITS;
        else
            n = int'(qubits_cfg);
        dim = 1 << n;
        case (kind)
            REQ_LOAD:
            begin
                if (idx < dim)
                begin
                    amp_re[idx] = re_in;
                    amp_im[idx] = im_in;
                    r.status = 1'b0;
                end
            end
            REQ_READ:
            begin
                if (idx < dim)
                begin
                    r.re = amp_re[idx];
                    r.im = amp_im[idx];
                    r.status = 1'b0;
                end
            end
            REQ_GATE:
            begin
                if (gk inside {GATE_X, GATE_Y, GATE_Z} && q < n)
                begin
                    bit_mask = 1 << q;
                    for (int i = 0; i < dim; i++)
                    begin
                        if ((i & bit_mask) == 0)
                        begin
                            j = i | bit_mask;
                            r0 = amp_re[i];
                            i0 = amp_im[i];
                            r1 = amp_re[j];
                            i1 = amp_im[j];
                            case (gk)
                                GATE_X:
                                begin
                                    amp_re[i] = r1;
                                    amp_im[i] = i1;
                                    amp_re[j] = r0;
                                    amp_im[j] = i0;
                                end
                                GATE_Y:
                                begin
                                    amp_re[i] = i1;
                                    amp_im[i] = negate_sat(r1);
                                    amp_re[j] = negate_sat(i0);
                                    amp_im[j] = r0;
                                end
                                default:
                                begin
                                    amp_re[j] = negate_sat(r1);
                                    amp_im[j] = negate_sat(i1);
                                end
                            endcase
                        end
                    end
                    r.status = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            qubits_cfg = QUBITS_RESET;
            awaited_replies.delete();
            pending = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                qubits_cfg = cfg.qubits_in_use;
            if (req.valid && req.ready)
                awaited_replies.push_back(serve_request(req.req_type, req.amp_index,
                    req.real_in, req.imag_in, req.gate_kind, req.target_qubit));
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_replies.size() == 0)
                    report("response transaction with no request outstanding");
                else
                begin
                    want = awaited_replies.pop_front();
                    if (rsp.real_out !== want.re)
                        report($sformatf("real_out expected %h, got %h", want.re, rsp.real_out));
                    if (rsp.imag_out !== want.im)
                        report($sformatf("imag_out expected %h, got %h", want.im, rsp.imag_out));
                    if (rsp.status !== want.status)
                        report($sformatf("status expected %b, got %b", want.status, rsp.status));
                end
            end
            pending = awaited_replies.size();
        end
    end

endmodule

>>> bench/pauli_gate_state_vector_engine_tb.sv
`timescale 1ns / 1ps

module pauli_gate_state_vector_engine_tb;
    import pgse_pkg::*;

    localparam logic [REQ_TYPE_W-1:0] REQ_UNKNOWN  = 2'd3;
    localparam logic [GATE_W-1:0]     GATE_UNKNOWN = 2'd3;
    localparam logic [PART_W-1:0]     PART_MAX     = 16'h7fff;
    localparam logic [PART_W-1:0]     PART_MIN     = 16'h8000;
    localparam int                    NUM_PHASES   = 10;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;

    pgse_req_if req_ch ();
    pgse_rsp_if rsp_ch ();
    pgse_cfg_if cfg_ch ();

    pauli_gate_state_vector_engine uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    pauli_gate_state_vector_engine_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg        (cfg_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    bit  written_map [1024];
    int  cur_n;
    int  cur_dim;
    bit  calm;
    int  hold_request;
    int  items_sent;
    int  gates_sent;
    int  settings_used;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    initial
    begin
        #15_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [PART_W-1:0] rnd_part();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return PART_MAX;
        if (r < 8)
            return PART_MIN;
        if (r < 11)
            return '0;
        if (r < 14)
            return '1;
        return PART_W'($urandom());
    endfunction

    // Response side: random stalls, plus a long hold-off when the stimulus asks for one.
    initial
    begin : rsp_side
        int stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic send_request(
        input logic [REQ_TYPE_W-1:0] kind,
        input logic [INDEX_W-1:0]    idx,
        input logic [PART_W-1:0]     re_v,
        input logic [PART_W-1:0]     im_v,
        input logic [GATE_W-1:0]     gk,
        input logic [QUBIT_W-1:0]    q
    );
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.amp_index    <= idx;
        req_ch.real_in      <= re_v;
        req_ch.imag_in      <= im_v;
        req_ch.gate_kind    <= gk;
        req_ch.target_qubit <= q;
        do @(posedge clk); while (!req_ch.ready);
        items_sent++;
        if (kind == REQ_GATE)
            gates_sent++;
    endtask

    task automatic send_load(input logic [INDEX_W-1:0] idx, input logic [PART_W-1:0] re_v,
                             input logic [PART_W-1:0] im_v);
        send_request(REQ_LOAD, idx, re_v, im_v, GATE_W'($urandom()), QUBIT_W'($urandom()));
        if (idx < cur_dim)
            written_map[idx] = 1'b1;
    endtask

    task automatic send_read(input logic [INDEX_W-1:0] idx);
        send_request(REQ_READ, idx, PART_W'($urandom()), PART_W'($urandom()),
                     GATE_W'($urandom()), QUBIT_W'($urandom()));
    endtask

    task automatic send_gate(input logic [GATE_W-1:0] gk, input logic [QUBIT_W-1:0] q);
        send_request(REQ_GATE, INDEX_W'($urandom()), PART_W'($urandom()), PART_W'($urandom()),
                     gk, q);
    endtask

    task automatic send_unknown();
        send_request(REQ_UNKNOWN, INDEX_W'($urandom()), PART_W'($urandom()),
                     PART_W'($urandom()), GATE_W'($urandom()), QUBIT_W'($urandom()));
    endtask

    // Stop offering requests and wait until every response has come back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_qubits(input logic [QCFG_W-1:0] v);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.qubits_in_use <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (v == 0)
            cur_n = 1;
        else if (v > 10)
            cur_n = 10;
        else
            cur_n = int'(v);
        cur_dim = 1 << cur_n;
        settings_used++;
    endtask

    initial
    begin
        int phase_cfg [NUM_PHASES];
        int phase_items [NUM_PHASES];
        int r;
        logic [INDEX_W-1:0] idx;

        phase_cfg   = '{1, 2, 3, 5, 4, 6, 7, 2, 8, 3};
        phase_items = '{30, 30, 30, 30, 30, 30, 30, 30, 30, 30};

        rst_n = 1'b0;
        cur_n = 10;
        cur_dim = 1024;
        calm = 1'b0;
        hold_request = 0;
        items_sent = 0;
        gates_sent = 0;
        settings_used = 0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_LOAD;
        req_ch.amp_index    <= '0;
        req_ch.real_in      <= '0;
        req_ch.imag_in      <= '0;
        req_ch.gate_kind    <= GATE_X;
        req_ch.target_qubit <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.qubits_in_use <= QUBITS_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset qubit count: rejections that never touch the store,
        // then the index extremes.
        send_unknown();
        send_gate(GATE_UNKNOWN, 4'd0);
        send_gate(GATE_X, 4'd10);
        send_gate(GATE_Z, 4'd15);
        send_gate(GATE_Y, 4'd12);
        send_load(10'd1023, PART_MAX, PART_MIN);
        send_read(10'd1023);
        send_load(10'd0, PART_MIN, PART_MAX);
        send_read(10'd0);
        drain();

        // A count of zero acts as one qubit: a two-entry vector exercises every gate,
        // including negation of the most negative value.
        write_qubits(4'd0);
        send_load(10'd0, PART_MIN, 16'h1234);
        send_load(10'd1, PART_MAX, PART_MIN);
        send_load(10'd2, 16'h5555, 16'haaaa);
        send_read(10'd2);
        send_read(10'd1023);
        send_gate(GATE_Y, 4'd0);
        send_read(10'd0);
        send_read(10'd1);
        send_gate(GATE_Z, 4'd0);
        send_read(10'd0);
        send_read(10'd1);
        send_gate(GATE_X, 4'd0);
        send_read(10'd0);
        send_read(10'd1);
        send_gate(GATE_X, 4'd1);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            write_qubits(QCFG_W'(phase_cfg[p]));
            calm = (p == 2);
            // Every amplitude in range must hold a value before a read or gate may touch it.
            for (int i = 0; i < cur_dim; i++)
                if (!written_map[i])
                    send_load(INDEX_W'(i), rnd_part(), rnd_part());
            if (p == 3)
            begin
                calm = 1'b1;
                hold_request = 300;
            end
            for (int k = 0; k < phase_items[p]; k++)
            begin
                if (p == 3 && k == 20)
                    calm = 1'b0;
                r = $urandom_range(0, 99);
                if (r < 35)
                begin
                    idx = ($urandom_range(0, 9) == 0) ? INDEX_W'($urandom())
                                                      : INDEX_W'($urandom_range(0, cur_dim - 1));
                    send_load(idx, rnd_part(), rnd_part());
                end
                else if (r < 65)
                begin
                    idx = ($urandom_range(0, 9) == 0) ? INDEX_W'($urandom())
                                                      : INDEX_W'($urandom_range(0, cur_dim - 1));
                    send_read(idx);
                end
                else if (r < 88)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_gate(GATE_W'($urandom_range(0, 2)), QUBIT_W'($urandom_range(0, 15)));
                    else
                        send_gate(GATE_W'($urandom_range(0, 2)),
                                  QUBIT_W'($urandom_range(0, cur_n - 1)));
                end
                else if (r < 94)
                    send_unknown();
                else
                    send_gate(GATE_UNKNOWN, QUBIT_W'($urandom()));
                if ($urandom_range(0, 99) < 2)
                    drain();
            end
        end

        // A count above the maximum acts as the maximum: the top index is in range and
        // qubits from ten upward are rejected.
        drain();
        write_qubits(4'd15);
        send_read(10'd1023);
        send_load(10'd512, rnd_part(), rnd_part());
        send_read(10'd512);
        send_gate(GATE_X, 4'd10);
        send_gate(GATE_Z, 4'd15);

        drain();
        calm = 1'b0;
        $display("Ran %0d requests, %0d of them gates, over %0d qubit-count settings",
                 items_sent, gates_sent, settings_used);
        $display("(a count of zero and one above the maximum included); %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
